>>> design/grs_pkg.sv
// Shared types for the group reverse stream block.
package grs_pkg;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_DRAIN_REV,
    ST_DRAIN_FWD
  } state_t;

  // Shift command broadcast to every cell of the chain.
  typedef struct packed {
    logic shr;  // take the left neighbor's word (push side)
    logic shl;  // take the right neighbor's word (pop side)
  } shift_t;

  // Result-side status from the controller to the top level.
  typedef struct packed {
    logic valid;
    logic run_end;
    logic seq_end;
    logic from_tail;  // result sits in the last cell instead of the first
  } out_stat_t;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 5;

endpackage

>>> design/grs_cell.sv
// One storage cell of the bidirectional shift chain.
module grs_cell (
  input  logic                         clk,
  input  grs_pkg::shift_t              sh,
  input  logic [grs_pkg::DATA_W-1:0]   from_prev,
  input  logic [grs_pkg::DATA_W-1:0]   from_next,
  output logic [grs_pkg::DATA_W-1:0]   q
);
  import grs_pkg::*;

  always_ff @(posedge clk) begin
    if (sh.shr) begin
      q <= from_prev;
    end else if (sh.shl) begin
      q <= from_next;
    end
  end

endmodule

>>> design/grs_ctrl.sv
// Sequencer: fill tracking, group size register, drain counting and handshakes.
module grs_ctrl #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [grs_pkg::CFG_W-1:0]  cfg_data,
  input  logic                       in_valid,
  input  logic                       in_last,
  output logic                       in_ready,
  input  logic                       out_ready,
  output grs_pkg::out_stat_t         stat,
  output grs_pkg::shift_t            sh
);
  import grs_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_GROUP + 1);
  localparam int unsigned IDX_W = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

  state_t               state, state_next;
  logic [CFG_W-1:0]     group_size;
  logic [CNT_W-1:0]     fill;
  logic [CNT_W-1:0]     remaining;
  logic [IDX_W-1:0]     pos;
  logic                 seq_end;

  logic [7:0]           k_eff;
  logic [7:0]           n_ext;
  logic                 in_acc;
  logic                 out_acc;
  logic                 group_full;
  logic                 final_one;
  logic                 at_tail;

  always_comb begin
    if (group_size == '0) begin
      k_eff = 8'd1;
    end else if ({3'b000, group_size} > 8'(MAX_GROUP)) begin
      k_eff = 8'(MAX_GROUP);
    end else begin
      k_eff = {3'b000, group_size};
    end
  end

  assign n_ext      = 8'(fill) + 8'd1;
  assign group_full = (n_ext >= k_eff);
  assign in_acc     = in_valid && in_ready;
  assign out_acc    = stat.valid && out_ready;
  assign final_one  = (remaining == CNT_W'(1));
  assign at_tail    = (pos == IDX_W'(MAX_GROUP - 1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_COLLECT: begin
        if (in_acc) begin
          if (group_full) begin
            state_next = ST_DRAIN_REV;
          end else if (in_last) begin
            state_next = ST_DRAIN_FWD;
          end
        end
      end
      ST_DRAIN_REV, ST_DRAIN_FWD: begin
        if (out_acc && final_one) begin
          state_next = ST_COLLECT;
        end
      end
      default: state_next = ST_COLLECT;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    stat.valid     = 1'b0;
    stat.run_end   = final_one;
    stat.seq_end   = 1'b0;
    stat.from_tail = 1'b0;
    sh.shr         = 1'b0;
    sh.shl         = 1'b0;
    unique case (state)
      ST_COLLECT: begin
        in_ready = 1'b1;
        sh.shr   = in_acc;
      end
      ST_DRAIN_REV: begin
        stat.valid   = 1'b1;
        stat.seq_end = final_one && seq_end;
        sh.shl       = out_acc;
      end
      ST_DRAIN_FWD: begin
        // walk the oldest item to the last cell, then pop from there
        stat.valid     = at_tail;
        stat.seq_end   = final_one;
        stat.from_tail = 1'b1;
        sh.shr         = !at_tail || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_COLLECT;
      group_size <= CFG_W'(1);
      fill       <= '0;
      remaining  <= '0;
      pos        <= '0;
      seq_end    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        group_size <= cfg_data;
      end
      if (in_acc) begin
        if (group_full || in_last) begin
          fill      <= '0;
          remaining <= CNT_W'(n_ext);
          pos       <= IDX_W'(fill);
          seq_end   <= in_last;
        end else begin
          fill <= CNT_W'(n_ext);
        end
      end
      if (out_acc) begin
        remaining <= remaining - CNT_W'(1);
      end
      if (state == ST_DRAIN_FWD && !at_tail) begin
        pos <= pos + IDX_W'(1);
      end
    end
  end

endmodule

>>> design/group_reverse_stream_core.sv
// Top level of the group reverse stream block: cell chain, controller, assertions.
//
// Items enter a row of MAX_GROUP word cells, newest at the first cell, one per
// cycle while no group is being emitted. When a group reaches the configured
// size k (clamped to 1..MAX_GROUP) it is popped newest first from the first
// cell, one result per cycle while out_ready is high. A partial group closed
// by last_item is shifted toward the last cell until its oldest item reaches
// it, then popped there in arrival order. Input is held off (in_ready low)
// from the transaction that closes a group until its final result is taken;
// the shift chain itself is the output register. Write group_size through
// cfg_we and cfg_data only while the block is idle.
module group_reverse_stream_core #(
  parameter int unsigned MAX_GROUP = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [grs_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [grs_pkg::DATA_W-1:0] value,
  input  logic                              last_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [grs_pkg::DATA_W-1:0] out_value,
  output logic                              last_of_run,
  output logic                              end_of_sequence
);
  import grs_pkg::*;

  shift_t              sh;
  out_stat_t           stat;
  logic [DATA_W-1:0]   cell_q [MAX_GROUP];

  grs_ctrl #(
    .MAX_GROUP (MAX_GROUP)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_last   (last_item),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .sh        (sh)
  );

  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic [DATA_W-1:0] next_d;

    if (i == 0) begin : g_head
      assign prev_d = value;
    end else begin : g_mid
      assign prev_d = cell_q[i-1];
    end
    if (i == MAX_GROUP - 1) begin : g_tail
      assign next_d = cell_q[i];
    end else begin : g_inner
      assign next_d = cell_q[i+1];
    end

    grs_cell u_cell (
      .clk       (clk),
      .sh        (sh),
      .from_prev (prev_d),
      .from_next (next_d),
      .q         (cell_q[i])
    );
  end

  assign out_valid       = stat.valid;
  assign out_value       = stat.from_tail ? $signed(cell_q[MAX_GROUP-1]) : $signed(cell_q[0]);
  assign last_of_run     = stat.run_end;
  assign end_of_sequence = stat.seq_end;

  // Input and output never both open: one group in flight at a time.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open while a result is pending");

  a_seq_end_on_run_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && end_of_sequence) |-> last_of_run)
    else $error("end_of_sequence without last_of_run");

  // After the final result of a burst is taken, input reopens.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run) |=> in_ready)
    else $error("input not reopened after burst end");

  // A closing transaction starts a drain: input closes on the next cycle.
  a_close: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_item) |=> !in_ready)
    else $error("input still open after sequence end");

endmodule
